// ===== rtl/mts_pkg.sv =====
// Shared types, constants and delimiter tables for the sentence splitter.
package mts_pkg;

  // Default window size: longest delimiter token in bytes
  localparam int MTS_MAX_TOKEN_BYTES = 3;
  // Chinese table entries in use
  localparam int TOKEN_COUNT = 22;
  localparam int TOK_ROWS = 32;
  localparam int ROW_W = $clog2(TOK_ROWS);
  localparam int LEN_W = 3;

  // token_set register codes
  localparam logic TOKEN_SET_TIBETAN = 1'b0;
  localparam logic TOKEN_SET_CHINESE = 1'b1;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_delimiter;
    logic       pair_end;
    logic       line_end;
  } result_t;

  // Token patterns, first byte in the top byte lane
  localparam logic [31:0] CN_TOK [TOK_ROWS] = '{
    32'he3808200, 32'hefbc8c00, 32'he3808100, 32'hefbc9b00,
    32'hefbc9a00, 32'hefbc9f00, 32'hefbc8100, 32'he2809c00,
    32'he2809d00, 32'he2809800, 32'he2809900, 32'he2959700,
    32'he2959a00, 32'hefbc8800, 32'hefbc8900, 32'he280a600,
    32'he2809400, 32'he3808a00, 32'he3808b00, 32'he3808800,
    32'he3808900, 32'he280a200, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  localparam logic [LEN_W-1:0] CN_LEN [TOK_ROWS] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  // Tibetan: space and shad
  localparam logic [31:0] TB_TOK [2] = '{32'h20000000, 32'he0bc8d00};
  localparam logic [LEN_W-1:0] TB_LEN [2] = '{3'd1, 3'd3};

  function automatic logic [31:0] tok_pattern(input logic set, input logic [ROW_W-1:0] t);
    logic [31:0] pat;
    if (set == TOKEN_SET_CHINESE) begin
      pat = CN_TOK[t];
    end else if (t < ROW_W'(2)) begin
      pat = TB_TOK[t[0]];
    end else begin
      pat = 32'h0;
    end
    return pat;
  endfunction

  // Length 0 marks an unused row
  function automatic logic [LEN_W-1:0] tok_len(input logic set, input logic [ROW_W-1:0] t);
    logic [LEN_W-1:0] len;
    if (set == TOKEN_SET_CHINESE) begin
      len = ({1'b0, t} < (ROW_W + 1)'(TOKEN_COUNT)) ? CN_LEN[t] : '0;
    end else if (t < ROW_W'(2)) begin
      len = TB_LEN[t[0]];
    end else begin
      len = '0;
    end
    return len;
  endfunction

endpackage

// ===== rtl/mts_if.sv =====
// Valid/ready channel interfaces for text bytes in and tagged bytes out.
interface mts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_last;

  modport source(output valid, output in_byte, output line_last, input ready);
  modport sink(input valid, input in_byte, input line_last, output ready);
endinterface

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_delimiter;
  logic       pair_end;
  logic       line_end;

  modport source(output valid, output out_byte, output is_delimiter, output pair_end,
                 output line_end, input ready);
  modport sink(input valid, input out_byte, input is_delimiter, input pair_end,
               input line_end, output ready);
endinterface

// ===== rtl/mts_front.sv =====
// Front end: look-ahead window, parallel token match and byte classification.
module mts_front #(
  parameter int MAX_TOKEN_BYTES = mts_pkg::MTS_MAX_TOKEN_BYTES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  mts_in_if.sink                                 in_s,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data,
  input  logic                                   q_room,
  output logic [$clog2(MAX_TOKEN_BYTES+1)-1:0]   wr_cnt,
  output mts_pkg::result_t                       wr_data [MAX_TOKEN_BYTES]
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 1);
  localparam int PD    = (MAX_TOKEN_BYTES > 1) ? MAX_TOKEN_BYTES - 1 : 1;

  logic             token_set_r;
  logic [7:0]       pend_r [PD];
  logic [7:0]       pend_nxt [PD];
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic             accept;
  logic [CNT_W-1:0] win_n;
  logic [7:0]       win [MAX_TOKEN_BYTES];
  logic             m_wait [MAX_TOKEN_BYTES];
  logic [LEN_W-1:0] m_len [MAX_TOKEN_BYTES];
  logic             rel [MAX_TOKEN_BYTES];
  logic             dlm [MAX_TOKEN_BYTES];
  logic             pe [MAX_TOKEN_BYTES];
  logic [CNT_W-1:0] rel_n;

  assign in_s.ready = q_room;
  assign accept     = in_s.valid && q_room;
  assign win_n      = pend_cnt_r + CNT_W'(1);

  // Window: held bytes, then the new byte
  for (genvar i = 0; i < MAX_TOKEN_BYTES; i++) begin : g_win
    if (i < MAX_TOKEN_BYTES - 1) begin : g_held
      always_comb begin
        if (CNT_W'(i) < pend_cnt_r) begin
          win[i] = pend_r[i];
        end else if (CNT_W'(i) == pend_cnt_r) begin
          win[i] = in_s.in_byte;
        end else begin
          win[i] = 8'h00;
        end
      end
    end else begin : g_tail
      assign win[i] = (CNT_W'(i) == pend_cnt_r) ? in_s.in_byte : 8'h00;
    end
  end

  // Match at every start position; lowest table row that matches or waits wins
  for (genvar p = 0; p < MAX_TOKEN_BYTES; p++) begin : g_match
    always_comb begin
      logic [CNT_W-1:0] rem;
      logic [31:0]      pat;
      logic [LEN_W-1:0] len;
      logic             ok;
      rem       = win_n - CNT_W'(p);
      m_wait[p] = 1'b0;
      m_len[p]  = '0;
      for (int t = TOK_ROWS - 1; t >= 0; t--) begin
        pat = tok_pattern(token_set_r, ROW_W'(t));
        len = tok_len(token_set_r, ROW_W'(t));
        ok  = (len != '0) && (int'(len) <= MAX_TOKEN_BYTES);
        for (int i = 0; i < 4; i++) begin
          if (p + i < MAX_TOKEN_BYTES) begin
            if (i < int'(len) && i < int'(rem) && win[p+i] != pat[31-8*i -: 8]) begin
              ok = 1'b0;
            end
          end
        end
        if (ok && (int'(len) <= int'(rem) || !in_s.line_last)) begin
          m_wait[p] = int'(len) > int'(rem);
          m_len[p]  = len;
        end
      end
    end
  end

  // Walk the window: tokens consume bytes, a partial match stops release
  always_comb begin
    logic             stop;
    logic [LEN_W-1:0] skip;
    stop  = 1'b0;
    skip  = '0;
    rel_n = '0;
    for (int p = 0; p < MAX_TOKEN_BYTES; p++) begin
      rel[p] = 1'b0;
      dlm[p] = 1'b0;
      pe[p]  = 1'b0;
      if (CNT_W'(p) < win_n && !stop) begin
        if (skip != '0) begin
          rel[p] = 1'b1;
          dlm[p] = 1'b1;
          pe[p]  = (skip == LEN_W'(1));
          skip   = skip - LEN_W'(1);
        end else if (m_wait[p]) begin
          stop = 1'b1;
        end else if (m_len[p] != '0) begin
          rel[p] = 1'b1;
          dlm[p] = 1'b1;
          pe[p]  = (m_len[p] == LEN_W'(1));
          skip   = m_len[p] - LEN_W'(1);
        end else begin
          rel[p] = 1'b1;
        end
      end
      if (rel[p]) begin
        rel_n = rel_n + CNT_W'(1);
      end
    end
  end

  // Result words for the released prefix
  always_comb begin
    logic fin;
    for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
      fin                       = in_s.line_last && (CNT_W'(i + 1) == rel_n);
      wr_data[i].out_byte       = win[i];
      wr_data[i].is_delimiter   = dlm[i];
      wr_data[i].pair_end       = pe[i] || (fin && !dlm[i]);
      wr_data[i].line_end       = fin;
    end
    wr_cnt = accept ? rel_n : '0;
  end

  // Bytes left undecided shift down to the front of the held set
  always_comb begin
    for (int i = 0; i < PD; i++) begin
      pend_nxt[i] = pend_r[i];
      for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
        if (int'(rel_n) + i == j) begin
          pend_nxt[i] = win[j];
        end
      end
    end
    pend_cnt_nxt = win_n - rel_n;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_set_r <= TOKEN_SET_CHINESE;
      pend_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        token_set_r <= cfg_wr_data;
      end
      if (accept) begin
        pend_cnt_r <= pend_cnt_nxt;
      end
    end
  end

  // Held bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  // End of line flushes every held byte
  a_line_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_s.line_last) |=> (pend_cnt_r == '0))
    else $error("held bytes survive end of line");

  // Never more held bytes than the window leaves room for
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pend_cnt_r) <= MAX_TOKEN_BYTES - 1)
    else $error("held byte count out of range");

endmodule

// ===== rtl/mts_fifo.sv =====
// Result queue: takes up to one window of words per cycle, gives one per cycle on pop.
module mts_fifo #(
  parameter int MAX_TOKEN_BYTES = mts_pkg::MTS_MAX_TOKEN_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(MAX_TOKEN_BYTES+1)-1:0] wr_cnt,
  input  mts_pkg::result_t                     wr_data [MAX_TOKEN_BYTES],
  output logic                                 room,
  input  logic                                 pop,
  output logic                                 rd_valid,
  output mts_pkg::result_t                     rd_data
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 1);
  localparam int QD    = 2 ** $clog2(2 * MAX_TOKEN_BYTES);
  localparam int PTR_W = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  result_t          mem [QD];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  count_r;

  assign room     = (QC_W'(QD) - count_r) >= QC_W'(MAX_TOKEN_BYTES);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(wr_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + QC_W'(wr_cnt) - QC_W'(pop);
    end
  end

  // Storage: a burst lands in consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
      if (CNT_W'(i) < wr_cnt) begin
        mem[wr_ptr_r + PTR_W'(i)] <= wr_data[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_cnt != '0) |-> (int'(count_r) + int'(wr_cnt) <= QD))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue read while empty");

  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0]))
    else $error("queue pointers disagree with fill level");

endmodule

// ===== rtl/mts_back.sv =====
// Back end: output register that presents one tagged word per handshake.
module mts_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_valid,
  input  mts_pkg::result_t rd_data,
  output logic             pop,
  mts_out_if.source        out_m
);
  import mts_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Refill whenever the register is empty or being drained
  assign pop = rd_valid && (!valid_r || out_m.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_m.ready) begin
      valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= rd_data;
    end
  end

  assign out_m.valid        = valid_r;
  assign out_m.out_byte     = data_r.out_byte;
  assign out_m.is_delimiter = data_r.is_delimiter;
  assign out_m.pair_end     = data_r.pair_end;
  assign out_m.line_end     = data_r.line_end;

endmodule

// ===== rtl/multi_token_sentence_splitter.sv =====
// Top level of the multi-token sentence splitter.
//
//   channel  direction  words / fields
//   in_s     in         in_byte[7:0], line_last
//   out_m    out        out_byte[7:0], is_delimiter, pair_end, line_end
//   cfg_*    in         cfg_wr_en, cfg_wr_data = token_set
//
// One input byte per cycle while the queue has room; every byte leaves as exactly one
// output word. The front takes a byte whenever the result queue has room for a full
// window (MAX_TOKEN_BYTES words); the queue drains one word per cycle out while out_m
// is not stalled. out_m.valid rises once a word has passed the queue and the output
// register, later while a byte waits on a partial token match. Reset is synchronous:
// clears held bytes, queue and output valid, and sets token_set to the Chinese set.
// out_m stalls back up through the queue to in_s.ready without losing words.
module multi_token_sentence_splitter #(
  parameter int MAX_TOKEN_BYTES = mts_pkg::MTS_MAX_TOKEN_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  mts_in_if.sink    in_s,
  mts_out_if.source out_m,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 1);

  logic [CNT_W-1:0] wr_cnt;
  result_t          wr_data [MAX_TOKEN_BYTES];
  logic             q_room;
  logic             pop;
  logic             rd_valid;
  result_t          rd_data;

  mts_front #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_room     (q_room),
    .wr_cnt     (wr_cnt),
    .wr_data    (wr_data)
  );

  mts_fifo #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_cnt  (wr_cnt),
    .wr_data (wr_data),
    .room    (q_room),
    .pop     (pop),
    .rd_valid(rd_valid),
    .rd_data (rd_data)
  );

  mts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_valid(rd_valid),
    .rd_data (rd_data),
    .pop     (pop),
    .out_m   (out_m)
  );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the sentence splitter: byte stimulus, tag prediction and word checks.
`timescale 1ns / 1ps

module tb_top;
  import mts_pkg::*;

  // Cycles allowed after the last expected word before the block counts as idle
  localparam int DRAIN_CYCLES = 12;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   bytes_sent;
  int   tx_calm;
  int   rx_calm;

  mts_in_if  in_ch();
  mts_out_if out_ch();

  multi_token_sentence_splitter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_ch),
    .out_m       (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Tags each byte as content or delimiter and queues the words the block must send
  class tag_predictor;
    localparam int CN_MARKS = 22;

    logic       token_set;
    logic [7:0] held[2];
    int         held_cnt;
    logic [7:0] win[3];
    result_t    tagged_q[$];
    int         errors;

    function new();
      token_set = TOKEN_SET_CHINESE;
      held_cnt  = 0;
      errors    = 0;
    endfunction

    // Delimiter t of a set, first byte in the top lane
    static function void tok_of(input logic set, input int t, output logic [23:0] pat,
                                output int len);
      len = 3;
      if (set == TOKEN_SET_CHINESE) begin
        case (t)
          0:  pat = 24'he38082;
          1:  pat = 24'hefbc8c;
          2:  pat = 24'he38081;
          3:  pat = 24'hefbc9b;
          4:  pat = 24'hefbc9a;
          5:  pat = 24'hefbc9f;
          6:  pat = 24'hefbc81;
          7:  pat = 24'he2809c;
          8:  pat = 24'he2809d;
          9:  pat = 24'he28098;
          10: pat = 24'he28099;
          11: pat = 24'he29597;
          12: pat = 24'he2959a;
          13: pat = 24'hefbc88;
          14: pat = 24'hefbc89;
          15: pat = 24'he280a6;
          16: pat = 24'he28094;
          17: pat = 24'he3808a;
          18: pat = 24'he3808b;
          19: pat = 24'he38088;
          20: pat = 24'he38089;
          default: pat = 24'he280a2;
        endcase
      end else if (t == 0) begin
        // space
        pat = 24'h200000;
        len = 1;
      end else begin
        // shad
        pat = 24'he0bc8d;
      end
    endfunction

    function void set_token_set(input logic v);
      token_set = v;
    endfunction

    function int pending();
      return tagged_q.size();
    endfunction

    // Length of the winning token at pos, 0 for none, -1 while a better one may still come
    function int match_len(input int pos, input int rem, input bit last);
      logic [23:0] pat;
      int          n_tok;
      int          len;
      int          c;
      bit          ok;
      n_tok = (token_set == TOKEN_SET_CHINESE) ? CN_MARKS : 2;
      for (int t = 0; t < n_tok; t++) begin
        tok_of(token_set, t, pat, len);
        c  = (len < rem) ? len : rem;
        ok = 1'b1;
        for (int i = 0; i < c; i++) begin
          if (win[pos + i] != pat[23 - 8 * i -: 8]) ok = 1'b0;
        end
        if (ok) begin
          if (len <= rem) return len;
          if (!last) return -1;
        end
      end
      return 0;
    endfunction

    function void push_word(input logic [7:0] b, input logic delim, input logic pend);
      result_t r;
      r.out_byte     = b;
      r.is_delimiter = delim;
      r.pair_end     = pend;
      r.line_end     = 1'b0;
      tagged_q.insert(tagged_q.size(), r);
    endfunction

    // One accepted input byte
    function void take_byte(input logic [7:0] b, input logic last);
      result_t r;
      int      n;
      int      pos;
      int      m;
      int      first;
      n = held_cnt;
      for (int i = 0; i < n; i++) win[i] = held[i];
      win[n] = b;
      n++;
      pos   = 0;
      first = tagged_q.size();
      while (pos < n) begin
        m = match_len(pos, n - pos, last);
        if (m < 0) break;
        if (m > 0) begin
          for (int i = 0; i < m; i++) push_word(win[pos + i], 1'b1, i == m - 1);
          pos += m;
        end else begin
          push_word(win[pos], 1'b0, 1'b0);
          pos++;
        end
      end
      held_cnt = 0;
      for (int i = pos; i < n; i++) begin
        held[held_cnt] = win[i];
        held_cnt++;
      end
      // a trailing content run closes its pair at the end of the line
      if (last && tagged_q.size() > first) begin
        r = tagged_q.pop_back();
        r.line_end = 1'b1;
        if (!r.is_delimiter) r.pair_end = 1'b1;
        tagged_q.insert(tagged_q.size(), r);
      end
    endfunction

    function void check_word(input result_t got);
      result_t exp;
      if (tagged_q.size() == 0) begin
        $display("%0t: word with nothing pending: got byte=%02h delim=%b pair_end=%b line_end=%b",
                 $time, got.out_byte, got.is_delimiter, got.pair_end, got.line_end);
        errors++;
        return;
      end
      exp = tagged_q.pop_front();
      if (got.out_byte !== exp.out_byte || got.is_delimiter !== exp.is_delimiter ||
          got.pair_end !== exp.pair_end || got.line_end !== exp.line_end) begin
        $display("%0t: word mismatch: expected byte=%02h delim=%b pair_end=%b line_end=%b",
                 $time, exp.out_byte, exp.is_delimiter, exp.pair_end, exp.line_end);
        $display("%0t:                got      byte=%02h delim=%b pair_end=%b line_end=%b",
                 $time, got.out_byte, got.is_delimiter, got.pair_end, got.line_end);
        errors++;
      end
    endfunction
  endclass

  tag_predictor tagger = new();

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] content_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(33, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // Monitor: note accepted bytes, check accepted words
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tagger.take_byte(in_ch.in_byte, in_ch.line_last);
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte     = out_ch.out_byte;
        got.is_delimiter = out_ch.is_delimiter;
        got.pair_end     = out_ch.pair_end;
        got.line_end     = out_ch.line_end;
        tagger.check_word(got);
      end
    end
  end

  // Receiver: random stalls on the word channel
  initial begin : sink_stalls
    int n;
    out_ch.ready = 1'b0;
    rx_calm      = 0;
    @(posedge clk iff rst_n);
    forever begin
      n = pick_gap(rx_calm);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Send one byte; returns at the edge where it was taken, valid still high
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.line_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_token(input logic set, input int t, input logic last);
    logic [23:0] pat;
    int          len;
    tag_predictor::tok_of(set, t, pat, len);
    for (int i = 0; i < len; i++) send_byte(pat[23 - 8 * i -: 8], last && (i == len - 1));
  endtask

  // Register write once the block has drained
  task automatic write_token_set(input logic v);
    in_ch.valid <= 1'b0;
    while (tagger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tagger.set_token_set(v);
  endtask

  // One random line: tokens, content runs and broken token prefixes
  task automatic send_text_line(input logic set);
    logic [7:0]  txt[$];
    logic [23:0] pat;
    logic        tset;
    int          pieces;
    int          kind;
    int          len;
    int          cut;
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 99);
      tset = ($urandom_range(0, 9) == 0) ? ~set : set;
      tag_predictor::tok_of(tset, (tset == TOKEN_SET_CHINESE) ? $urandom_range(0, 21) :
                            $urandom_range(0, 1), pat, len);
      if (kind < 45) begin
        for (int i = 0; i < len; i++) txt.insert(txt.size(), pat[23 - 8 * i -: 8]);
      end else if (kind < 75 || len == 1) begin
        repeat ($urandom_range(1, 3)) txt.insert(txt.size(), content_byte());
      end else begin
        cut = $urandom_range(1, len - 1);
        for (int i = 0; i < cut; i++) txt.insert(txt.size(), pat[23 - 8 * i -: 8]);
        txt.insert(txt.size(), content_byte());
      end
    end
    for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // Leave a partial token held across a register change
  task automatic send_held_prefix(input logic set);
    logic [23:0] pat;
    int          len;
    tag_predictor::tok_of(set, (set == TOKEN_SET_CHINESE) ? $urandom_range(0, 21) : 1,
                          pat, len);
    send_byte(pat[23:16], 1'b0);
    send_byte(pat[15:8], 1'b0);
  endtask

  // Stimulus
  initial begin : stimulus
    int   start;
    logic phase_set;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.line_last = 1'b0;
    bytes_sent      = 0;
    tx_calm         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Chinese set straight from reset
    send_byte(8'h00, 1'b0);
    send_token(TOKEN_SET_CHINESE, 0, 1'b1);      // mark ends the line
    send_byte(8'he3, 1'b0);                      // partial mark that fails
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_token(TOKEN_SET_CHINESE, 1, 1'b0);
    send_byte(8'he2, 1'b0);                      // partial mark cut by end of line
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b1);                      // one-byte line of content

    // Tibetan set
    write_token_set(TOKEN_SET_TIBETAN);
    send_token(TOKEN_SET_TIBETAN, 0, 1'b0);
    send_token(TOKEN_SET_TIBETAN, 1, 1'b0);
    send_byte(8'he0, 1'b0);                      // shad prefix broken by a space
    send_byte(8'h20, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h20, 1'b1);                      // space ends the line
    send_byte(8'he0, 1'b0);
    send_byte(8'hbc, 1'b1);

    // Random lines, alternating sets, sometimes switching with bytes held
    for (int ph = 0; ph < 4; ph++) begin
      phase_set = (ph % 2 == 0) ? TOKEN_SET_CHINESE : TOKEN_SET_TIBETAN;
      write_token_set(phase_set);
      start = bytes_sent;
      while (bytes_sent - start < 40) send_text_line(phase_set);
      if (ph < 3 && $urandom_range(0, 1)) send_held_prefix(phase_set);
    end

    // Drain and finish
    in_ch.valid <= 1'b0;
    while (tagger.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tagger.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
